/* rtl/core/fpc_pkg.sv */
// Shared types and constants of the pixel format converter.
// Depends on nothing; every other file in rtl/core refers to it by scoped name.
package fpc_pkg;

  // Geometry
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned BPP_W      = 6;
  localparam int unsigned PCOUNT_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT = 2'd1;

  // Depth codes
  localparam logic [BPP_W-1:0] BPP_X555  = 6'd15;
  localparam logic [BPP_W-1:0] BPP_565   = 6'd16;
  localparam logic [BPP_W-1:0] BPP_RGB24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_RGB32 = 6'd32;
  localparam logic [BPP_W-1:0] BPP_RESET = BPP_565;

  typedef enum logic [1:0] {
    REQ_PAL_WR = 2'd0,
    REQ_UNPACK = 2'd1,
    REQ_PACK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  // What the back end has to do with a queued item
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,  // result fully formed, channels zero
    KIND_PAL_WR = 2'd1,  // store channels into the palette
    KIND_LOOKUP = 2'd2,  // channels come from the palette
    KIND_DIRECT = 2'd3   // result fully formed in the entry
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [31:0]       raw;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [SLOT_W-1:0] idx;
  } entry_t;

endpackage

/* rtl/core/pixel_format_converter.sv */
// Top level of the pixel format converter: configuration registers and wiring.
// Depends on fpc_pkg, fpc_front, fpc_queue and fpc_back.
//
//  channel   direction  handshake                 payload
//  command   in         start_i / busy_o          req_type_i, pixel_raw_i, red/green/blue_in_i,
//                                                 palette_slot_i
//  result    out        done_o (strobe, 1 cycle)  raw_out_o, red/green/blue_out_o, status_o
//  config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One command per clock while busy_o is low; the result strobe follows the transfer
// by way of the queue write, then the palette read register in the back end.
// Reset clears the registers, the queue and the palette valid bits at once, so no
// clearing pass: palette entries read back as zero until written.
// The result side cannot stall; busy_o rises only if the queue fills.
// Config is always ready and is meant to be written while the block is idle.
module pixel_format_converter #(
  parameter int unsigned PaletteEntries = fpc_pkg::PALETTE_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      req_type_i,
  input  logic [31:0]                     pixel_raw_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      blue_in_i,
  input  logic [fpc_pkg::SLOT_W-1:0]      palette_slot_i,
  // result
  output logic                            done_o,
  output logic [31:0]                     raw_out_o,
  output logic [7:0]                      red_out_o,
  output logic [7:0]                      green_out_o,
  output logic [7:0]                      blue_out_o,
  output logic [1:0]                      status_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [fpc_pkg::BPP_W-1:0]    bpp_q, bpp_d;
  logic [fpc_pkg::PCOUNT_W-1:0] pcount_q, pcount_d;

  logic            push, pop, full, empty;
  fpc_pkg::entry_t fr_entry, bk_entry;

  // Configuration registers; an index beyond the list is dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bpp_d    = bpp_q;
    pcount_d = pcount_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fpc_pkg::CFG_BPP:       bpp_d    = cfg_data_i[fpc_pkg::BPP_W-1:0];
        fpc_pkg::CFG_PAL_COUNT: pcount_d = cfg_data_i[fpc_pkg::PCOUNT_W-1:0];
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= fpc_pkg::BPP_RESET;
      pcount_q <= '0;
    end else begin
      bpp_q    <= bpp_d;
      pcount_q <= pcount_d;
    end
  end

  // Front end classifies each command in the cycle of its transfer
  fpc_front #(
    .PaletteEntries(PaletteEntries)
  ) u_front (
    .start_i        (start_i),
    .full_i         (full),
    .req_type_i     (req_type_i),
    .pixel_raw_i    (pixel_raw_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .palette_slot_i (palette_slot_i),
    .bpp_i          (bpp_q),
    .pal_count_i    (pcount_q),
    .busy_o         (busy_o),
    .push_o         (push),
    .entry_o        (fr_entry)
  );

  fpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fr_entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .entry_o (bk_entry)
  );

  // Back end drains one entry per cycle, so it never holds the queue
  assign pop = !empty;

  fpc_back #(
    .PaletteEntries(PaletteEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .entry_i     (bk_entry),
    .done_o      (done_o),
    .raw_out_o   (raw_out_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .status_o    (status_o)
  );

endmodule

/* rtl/core/fpc_front.sv */
// Front end: takes the command and classifies it into a queue entry.
// Depends on fpc_pkg; feeds fpc_queue.
module fpc_front #(
  parameter int unsigned PaletteEntries = fpc_pkg::PALETTE_ENTRIES
) (
  input  logic                          start_i,
  input  logic                          full_i,
  input  logic [1:0]                    req_type_i,
  input  logic [31:0]                   pixel_raw_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  input  logic [fpc_pkg::SLOT_W-1:0]    palette_slot_i,
  input  logic [fpc_pkg::BPP_W-1:0]     bpp_i,
  input  logic [fpc_pkg::PCOUNT_W-1:0]  pal_count_i,
  output logic                          busy_o,
  output logic                          push_o,
  output fpc_pkg::entry_t               entry_o
);

  logic is15, is16, is_bytes;
  logic idx_ok, slot_ok;

  assign is15     = (bpp_i == fpc_pkg::BPP_X555);
  assign is16     = (bpp_i == fpc_pkg::BPP_565);
  assign is_bytes = (bpp_i == fpc_pkg::BPP_RGB24) || (bpp_i == fpc_pkg::BPP_RGB32);

  assign idx_ok  = (pixel_raw_i < 32'(pal_count_i)) && (pixel_raw_i < 32'(PaletteEntries));
  assign slot_ok = ({1'b0, palette_slot_i} < (fpc_pkg::SLOT_W + 1)'(PaletteEntries));

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    entry_o        = '0;
    entry_o.kind   = fpc_pkg::KIND_NONE;
    entry_o.status = fpc_pkg::ST_OK;
    case (fpc_pkg::req_e'(req_type_i))
      fpc_pkg::REQ_PAL_WR: begin
        if (slot_ok) begin
          entry_o.kind  = fpc_pkg::KIND_PAL_WR;
          entry_o.red   = red_in_i;
          entry_o.green = green_in_i;
          entry_o.blue  = blue_in_i;
          entry_o.idx   = palette_slot_i;
        end else begin
          entry_o.status = fpc_pkg::ST_RANGE;
        end
      end
      fpc_pkg::REQ_UNPACK: begin
        entry_o.raw = pixel_raw_i;
        if (is15) begin
          // lowest kept bit copied into the vacated low bits
          entry_o.kind  = fpc_pkg::KIND_DIRECT;
          entry_o.red   = {pixel_raw_i[14:10], {3{pixel_raw_i[10]}}};
          entry_o.green = {pixel_raw_i[9:5],   {3{pixel_raw_i[5]}}};
          entry_o.blue  = {pixel_raw_i[4:0],   {3{pixel_raw_i[0]}}};
        end else if (is16) begin
          entry_o.kind  = fpc_pkg::KIND_DIRECT;
          entry_o.red   = {pixel_raw_i[15:11], {3{pixel_raw_i[11]}}};
          entry_o.green = {pixel_raw_i[10:5],  {2{pixel_raw_i[5]}}};
          entry_o.blue  = {pixel_raw_i[4:0],   {3{pixel_raw_i[0]}}};
        end else if (is_bytes) begin
          entry_o.kind  = fpc_pkg::KIND_DIRECT;
          entry_o.red   = pixel_raw_i[7:0];
          entry_o.green = pixel_raw_i[15:8];
          entry_o.blue  = pixel_raw_i[23:16];
        end else if (idx_ok) begin
          entry_o.kind = fpc_pkg::KIND_LOOKUP;
          entry_o.idx  = pixel_raw_i[fpc_pkg::SLOT_W-1:0];
        end else begin
          entry_o.status = fpc_pkg::ST_RANGE;
        end
      end
      fpc_pkg::REQ_PACK: begin
        if (is15) begin
          entry_o.raw = {17'd0, red_in_i[7:3], green_in_i[7:3], blue_in_i[7:3]};
        end else if (is16) begin
          entry_o.raw = {16'd0, red_in_i[7:3], green_in_i[7:2], blue_in_i[7:3]};
        end else if (is_bytes) begin
          entry_o.raw = {8'd0, blue_in_i, green_in_i, red_in_i};
        end else begin
          entry_o.status = fpc_pkg::ST_UNSUP;
        end
      end
      default: begin
        entry_o.kind = fpc_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

/* rtl/core/fpc_queue.sv */
// Short FIFO of classified entries between front and back end.
// Depends on fpc_pkg for the entry type and depth.
module fpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fpc_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output fpc_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (fpc_pkg::QUEUE_DEPTH > 1) ? $clog2(fpc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(fpc_pkg::QUEUE_DEPTH + 1);

  fpc_pkg::entry_t      slots_q [fpc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  assign full_o  = (count_q == CntW'(fpc_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(fpc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(fpc_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
`endif

endmodule

/* rtl/core/fpc_back.sv */
// Back end: palette store, lookup and result stage.
// Depends on fpc_pkg; drains fpc_queue one entry per cycle.
module fpc_back #(
  parameter int unsigned PaletteEntries = fpc_pkg::PALETTE_ENTRIES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_i,
  input  fpc_pkg::entry_t entry_i,
  output logic            done_o,
  output logic [31:0]     raw_out_o,
  output logic [7:0]      red_out_o,
  output logic [7:0]      green_out_o,
  output logic [7:0]      blue_out_o,
  output logic [1:0]      status_o
);

  localparam int unsigned IdxW = $clog2(PaletteEntries);

  logic [23:0]               mem [PaletteEntries];
  logic [PaletteEntries-1:0] vld_q;
  logic [IdxW-1:0]           idx;
  logic                      a_valid_q;
  fpc_pkg::entry_t           a_q;
  logic [23:0]               rdata_q;
  logic                      hit_q;
  logic [23:0]               chan;

  assign idx = entry_i.idx[IdxW-1:0];

  // valid bits stand in for clearing the store at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pop_i;
      if (pop_i && entry_i.kind == fpc_pkg::KIND_PAL_WR) begin
        vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      a_q <= entry_i;
      if (entry_i.kind == fpc_pkg::KIND_PAL_WR) begin
        mem[idx] <= {entry_i.red, entry_i.green, entry_i.blue};
      end
      if (entry_i.kind == fpc_pkg::KIND_LOOKUP) begin
        rdata_q <= mem[idx];
        hit_q   <= vld_q[idx];
      end
    end
  end

  always_comb begin
    case (a_q.kind)
      fpc_pkg::KIND_LOOKUP: chan = hit_q ? rdata_q : 24'd0;
      fpc_pkg::KIND_DIRECT: chan = {a_q.red, a_q.green, a_q.blue};
      default:              chan = 24'd0;
    endcase
  end

  assign done_o      = a_valid_q;
  assign raw_out_o   = a_q.raw;
  assign red_out_o   = chan[23:16];
  assign green_out_o = chan[15:8];
  assign blue_out_o  = chan[7:0];
  assign status_o    = a_q.status;

`ifndef ASSERT_OFF
  a_pop_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |=> done_o)
    else $error("popped entry produced no result strobe");
  a_palwr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && a_q.kind == fpc_pkg::KIND_PAL_WR) |->
      (raw_out_o == 32'd0 && red_out_o == 8'd0 && blue_out_o == 8'd0))
    else $error("palette write result carries data");
`endif

endmodule

/* tb/sv/pixel_conversion_checker.sv */
// Checker for the pixel format converter: watches the command, config and result channels,
// predicts each result from its own copy of the registers and the palette, and compares.
// Depends on fpc_pkg.
module pixel_conversion_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [1:0]                      req_type_i,
  input  logic [31:0]                     pixel_raw_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      blue_in_i,
  input  logic [fpc_pkg::SLOT_W-1:0]      palette_slot_i,
  input  logic                            done_i,
  input  logic [31:0]                     raw_out_i,
  input  logic [7:0]                      red_out_i,
  input  logic [7:0]                      green_out_i,
  input  logic [7:0]                      blue_out_i,
  input  logic [1:0]                      status_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  typedef struct packed {
    logic [31:0] raw;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  status;
  } pixel_res_t;

  logic [fpc_pkg::BPP_W-1:0]    depth_q;
  logic [fpc_pkg::PCOUNT_W-1:0] valid_entries_q;
  logic [23:0]                  palette_shadow [fpc_pkg::PALETTE_ENTRIES];
  pixel_res_t                   expected_pixels [$];
  int unsigned                  mismatch_total;

  assign fail_count_o = mismatch_total;

  // copy the lowest kept bit of a left-aligned channel into the lost bits below it
  function automatic logic [7:0] smear_low_bit(logic [7:0] ch, int unsigned lost);
    logic [7:0] fill;
    fill = (8'd1 << lost) - 8'd1;
    return ch[lost] ? (ch | fill) : ch;
  endfunction

  function automatic pixel_res_t convert_item(fpc_pkg::req_e req, logic [31:0] raw,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              logic [fpc_pkg::SLOT_W-1:0] slot);
    pixel_res_t  res;
    logic [23:0] entry;
    res = '0;
    case (req)
      fpc_pkg::REQ_PAL_WR: begin
        if (32'(slot) < fpc_pkg::PALETTE_ENTRIES) palette_shadow[slot] = {r, g, b};
        else res.status = fpc_pkg::ST_RANGE;
      end
      fpc_pkg::REQ_UNPACK: begin
        res.raw = raw;
        if (depth_q == fpc_pkg::BPP_X555) begin
          res.red   = smear_low_bit({raw[14:10], 3'b000}, 3);
          res.green = smear_low_bit({raw[9:5], 3'b000}, 3);
          res.blue  = smear_low_bit({raw[4:0], 3'b000}, 3);
        end else if (depth_q == fpc_pkg::BPP_565) begin
          res.red   = smear_low_bit({raw[15:11], 3'b000}, 3);
          res.green = smear_low_bit({raw[10:5], 2'b00}, 2);
          res.blue  = smear_low_bit({raw[4:0], 3'b000}, 3);
        end else if (depth_q == fpc_pkg::BPP_RGB24 || depth_q == fpc_pkg::BPP_RGB32) begin
          res.red   = raw[7:0];
          res.green = raw[15:8];
          res.blue  = raw[23:16];
        end else if (raw < 32'(valid_entries_q) && raw < fpc_pkg::PALETTE_ENTRIES) begin
          entry     = palette_shadow[raw[fpc_pkg::SLOT_W-1:0]];
          res.red   = entry[23:16];
          res.green = entry[15:8];
          res.blue  = entry[7:0];
        end else begin
          res.status = fpc_pkg::ST_RANGE;
        end
      end
      fpc_pkg::REQ_PACK: begin
        if (depth_q == fpc_pkg::BPP_X555)
          res.raw = {17'd0, r[7:3], g[7:3], b[7:3]};
        else if (depth_q == fpc_pkg::BPP_565)
          res.raw = {16'd0, r[7:3], g[7:2], b[7:3]};
        else if (depth_q == fpc_pkg::BPP_RGB24 || depth_q == fpc_pkg::BPP_RGB32)
          res.raw = {8'd0, b, g, r};
        else
          res.status = fpc_pkg::ST_UNSUP;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void log_mismatch(string what, pixel_res_t want, pixel_res_t got);
    if (mismatch_total < 10)
      $display("%s: want raw=%08h r=%02h g=%02h b=%02h st=%0d, got raw=%08h r=%02h g=%02h b=%02h st=%0d",
               what, want.raw, want.red, want.green, want.blue, want.status,
               got.raw, got.red, got.green, got.blue, got.status);
    mismatch_total++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_res_t want;
    pixel_res_t got;
    bit         pushed;
    bit         popped;
    if (!rst_ni) begin
      depth_q         = fpc_pkg::BPP_RESET;
      valid_entries_q = '0;
      foreach (palette_shadow[i]) palette_shadow[i] = '0;
      expected_pixels.delete();
      mismatch_total  = 0;
      pending_o      <= 0;
    end else begin
      pushed = 1'b0;
      popped = 1'b0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fpc_pkg::CFG_BPP:       depth_q = cfg_data_i[fpc_pkg::BPP_W-1:0];
          fpc_pkg::CFG_PAL_COUNT: valid_entries_q = cfg_data_i[fpc_pkg::PCOUNT_W-1:0];
          default: ;
        endcase
      end
      // results first: a result and a new command in one cycle belong to different items
      if (done_i) begin
        got = '{raw_out_i, red_out_i, green_out_i, blue_out_i, status_i};
        if (expected_pixels.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want   = expected_pixels.pop_front();
          popped = 1'b1;
          if (got !== want) log_mismatch("mismatch", want, got);
        end
      end
      if (start_i && !busy_i) begin
        expected_pixels.push_back(convert_item(fpc_pkg::req_e'(req_type_i), pixel_raw_i,
                                               red_in_i, green_in_i, blue_in_i,
                                               palette_slot_i));
        pushed = 1'b1;
      end
      pending_o <= pending_o + int'(pushed) - int'(popped);
    end
  end

endmodule

/* tb/sv/tb_pixel_format_converter.sv */
// Testbench top for the pixel format converter: clock, reset, command and config stimulus,
// watchdog and verdict. Depends on fpc_pkg, pixel_format_converter and
// pixel_conversion_checker.
module tb_pixel_format_converter;

  // Config indexes past the two real registers; writes there must change nothing.
  localparam logic [fpc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [fpc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam int unsigned STALL_LIMIT = 500;  // cycles with no transfer at all
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [1:0]                      req_type_i;
  logic [31:0]                     pixel_raw_i;
  logic [7:0]                      red_in_i;
  logic [7:0]                      green_in_i;
  logic [7:0]                      blue_in_i;
  logic [fpc_pkg::SLOT_W-1:0]      palette_slot_i;
  logic                            done_o;
  logic [31:0]                     raw_out_o;
  logic [7:0]                      red_out_o;
  logic [7:0]                      green_out_o;
  logic [7:0]                      blue_out_o;
  logic [1:0]                      status_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles;

  // Stimulus side view of the current config, used only to shape the random items.
  bit          palette_depth;
  int unsigned entries_cfg;

  pixel_format_converter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .pixel_raw_i    (pixel_raw_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .palette_slot_i (palette_slot_i),
    .done_o         (done_o),
    .raw_out_o      (raw_out_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  pixel_conversion_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .pixel_raw_i    (pixel_raw_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .palette_slot_i (palette_slot_i),
    .done_i         (done_o),
    .raw_out_i      (raw_out_o),
    .red_out_i      (red_out_o),
    .green_out_i    (green_out_o),
    .blue_out_i     (blue_out_o),
    .status_i       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: any transfer on any channel counts as progress. Reset cycles are exempt.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command and hold it until the transfer; start stays high on return so
  // that back-to-back commands need no extra assignment.
  task automatic send_item(input fpc_pkg::req_e req, input logic [31:0] raw,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [fpc_pkg::SLOT_W-1:0] slot);
    start_i        <= 1'b1;
    req_type_i     <= req;
    pixel_raw_i    <= raw;
    red_in_i       <= r;
    green_in_i     <= g;
    blue_in_i      <= b;
    palette_slot_i <= slot;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and wait for every outstanding result. The clock is awaited before pending
  // is read, so the checker has counted the last transfer.
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Registers are only touched with the block drained. Depth writes carry junk in the
  // data bits above the register width, which must be dropped.
  task automatic configure(input logic [fpc_pkg::BPP_W-1:0] depth,
                           input logic [fpc_pkg::PCOUNT_W-1:0] entries, input bit spare);
    wait_idle();
    if (spare)
      write_reg(($urandom_range(1) != 0) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                fpc_pkg::CFG_DATA_W'($urandom()));
    write_reg(fpc_pkg::CFG_BPP, {3'($urandom_range(7)), depth});
    write_reg(fpc_pkg::CFG_PAL_COUNT, entries);
    cfg_valid_i   <= 1'b0;
    palette_depth  = !(depth inside {fpc_pkg::BPP_X555, fpc_pkg::BPP_565,
                                     fpc_pkg::BPP_RGB24, fpc_pkg::BPP_RGB32});
    entries_cfg    = entries;
  endtask

  task automatic send_random();
    fpc_pkg::req_e req;
    logic [31:0]   raw;
    int unsigned   roll;
    roll = $urandom_range(99);
    if (roll < 20)      req = fpc_pkg::REQ_PAL_WR;
    else if (roll < 62) req = fpc_pkg::REQ_UNPACK;
    else if (roll < 95) req = fpc_pkg::REQ_PACK;
    else                req = fpc_pkg::REQ_NONE;
    raw = $urandom();
    // at palette depth most indexes are drawn from zero to eight past the valid count, so
    // both hits and out-of-range misses occur; the rest stay full-width
    if (palette_depth && $urandom_range(3) != 0) raw = $urandom_range(entries_cfg + 8);
    send_item(req, raw, 8'($urandom()), 8'($urandom()), 8'($urandom()),
              fpc_pkg::SLOT_W'($urandom()));
  endtask

  initial begin : stimulus
    logic [fpc_pkg::BPP_W-1:0]    depth;
    logic [fpc_pkg::PCOUNT_W-1:0] entries;
    int unsigned                  gap_pct;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_type_i     = '0;
    pixel_raw_i    = '0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    palette_slot_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    palette_depth  = 1'b0;
    entries_cfg    = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, starting from the reset config (565, no valid entries) ----
    send_item(fpc_pkg::REQ_PAL_WR, '0, 8'hff, 8'h00, 8'ha5, 8'd0);
    send_item(fpc_pkg::REQ_PAL_WR, '0, 8'hff, 8'hff, 8'hff, 8'd255);
    send_item(fpc_pkg::REQ_UNPACK, 32'hffff_ffff, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_UNPACK, 32'h0000_0000, '1, '1, '1, '1);
    // lowest kept bit of every channel set, upper half junk: low bits must smear
    send_item(fpc_pkg::REQ_UNPACK, 32'hdead_0821, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_PACK, '0, 8'hff, 8'hff, 8'hff, '0);
    send_item(fpc_pkg::REQ_PACK, '1, 8'h07, 8'h03, 8'h07, '1);  // dropped bits only
    send_item(fpc_pkg::REQ_NONE, '1, '1, '1, '1, '1);

    // x555: bit 15 ignored
    configure(fpc_pkg::BPP_X555, '0, 1'b1);
    send_item(fpc_pkg::REQ_UNPACK, 32'hffff_8421, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_PACK, '0, 8'hff, 8'hff, 8'hff, '0);

    configure(fpc_pkg::BPP_RGB24, '0, 1'b0);
    send_item(fpc_pkg::REQ_UNPACK, 32'hffff_ffff, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_PACK, '0, 8'h01, 8'h02, 8'h03, '0);

    configure(fpc_pkg::BPP_RGB32, '0, 1'b0);
    send_item(fpc_pkg::REQ_UNPACK, 32'h1234_5678, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_PACK, '0, 8'hff, 8'h00, 8'h80, '0);

    // palette depth with no valid entries: every lookup out of range, pack unsupported
    configure(6'd1, '0, 1'b1);
    send_item(fpc_pkg::REQ_UNPACK, 32'd0, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_PACK, '0, 8'h12, 8'h34, 8'h56, '0);

    // full palette: first and last entry hit, one past the end and a huge index miss
    configure(6'd8, 9'd256, 1'b0);
    send_item(fpc_pkg::REQ_UNPACK, 32'd0, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_UNPACK, 32'd255, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_UNPACK, 32'd256, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_UNPACK, 32'hffff_ffff, '0, '0, '0, '0);

    // count above the store size: the store bound still applies
    configure(6'd63, 9'd511, 1'b1);
    send_item(fpc_pkg::REQ_UNPACK, 32'd255, '0, '0, '0, '0);
    send_item(fpc_pkg::REQ_UNPACK, 32'd300, '0, '0, '0, '0);

    // ---- random phases, each with its own config and idling rate ----
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(7))
        0:       depth = fpc_pkg::BPP_X555;
        1:       depth = fpc_pkg::BPP_565;
        2:       depth = fpc_pkg::BPP_RGB24;
        3:       depth = fpc_pkg::BPP_RGB32;
        4:       depth = '0;
        5:       depth = '1;
        default: depth = fpc_pkg::BPP_W'($urandom_range(63));
      endcase
      case ($urandom_range(5))
        0:       entries = '0;
        1:       entries = 9'd256;
        2:       entries = '1;
        default: entries = fpc_pkg::PCOUNT_W'($urandom_range(1, 255));
      endcase
      configure(depth, entries, $urandom_range(2) == 0);

      // last two phases run flat out
      if (phase >= PHASES - 2) begin
        gap_pct = 0;
      end else begin
        case ($urandom_range(3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 30;
          default: gap_pct = 60;
        endcase
      end

      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < gap_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk_i);
        end
        send_random();
      end
    end

    // drain, then a short quiet spell to catch stray result strobes
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
